// ===== rtl/stbs_pkg.sv =====
`default_nettype none

package stbs_pkg;

    localparam int KEY_W   = 32;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    localparam int LOW_W   = 11;
    localparam int HIGH_W  = 12;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_CHECK   = 4'b0010,
        ST_COMPARE = 4'b0100,
        ST_DONE    = 4'b1000
    } state_t;

    typedef struct packed {
        logic load_we;
        logic start;
        logic probe;
        logic update;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic range_empty;
        logic cmp_eq;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/stbs_ctrl.sv =====
`default_nettype none

module stbs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             req_type,
    input  wire stbs_pkg::status_t status,
    output stbs_pkg::cmd_t        cmd
);
    import stbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (req_type == REQ_SEARCH) begin
                        cmd.start  = 1'b1;
                        state_next = ST_CHECK;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (status.range_empty) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                cmd.update = 1'b1;
                state_next = status.cmp_eq ? ST_DONE : ST_CHECK;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_compare_after_check: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COMPARE |-> $past(state_reg) == ST_CHECK)
        else $error("compare state not entered from check");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start || cmd.load_we) |-> state_reg == ST_IDLE)
        else $error("item taken outside idle");

    a_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

`default_nettype wire

// ===== rtl/stbs_datapath.sv =====
`default_nettype none

module stbs_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire stbs_pkg::cmd_t               cmd,
    output stbs_pkg::status_t                 status,
    input  wire logic [stbs_pkg::COUNT_W-1:0] entry_count,
    input  wire logic [stbs_pkg::INDEX_W-1:0] load_index,
    input  wire logic [stbs_pkg::KEY_W-1:0]   load_value,
    input  wire logic [stbs_pkg::KEY_W-1:0]   search_key,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic                              found
);
    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int MW = (AW > HIGH_W) ? AW : HIGH_W;

    logic [KEY_W-1:0] mem [TABLE_DEPTH];

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [LOW_W-1:0]        low_reg;
    logic [HIGH_W-1:0]       high_reg;
    logic [HIGH_W-1:0]       mid_reg;
    logic                    hit_reg;
    logic                    m_tvalid_reg;
    logic                    found_reg;

    logic [HIGH_W-1:0] count_clamped;
    logic [HIGH_W-1:0] span;
    logic [HIGH_W-1:0] mid_calc;
    logic [MW-1:0]     mid_ext;
    logic [LW-1:0]     load_ext;
    logic              load_ok;
    logic              cmp_eq;
    logic              cmp_lt;

    assign count_clamped = (32'(entry_count) > 32'(TABLE_DEPTH)) ?
                           HIGH_W'(TABLE_DEPTH) : HIGH_W'(entry_count);
    assign span      = high_reg - HIGH_W'(1) - HIGH_W'(low_reg);
    assign mid_calc  = HIGH_W'(low_reg) + (span >> 1);
    assign mid_ext   = MW'(mid_calc);
    assign load_ext  = LW'(load_index);
    assign load_ok   = 32'(load_index) < 32'(TABLE_DEPTH);
    assign cmp_eq    = rd_data_reg == key_reg;
    assign cmp_lt    = rd_data_reg < key_reg;

    assign status.range_empty = !(HIGH_W'(low_reg) < high_reg);
    assign status.cmp_eq      = cmp_eq;
    assign status.out_busy    = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign found    = found_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_we && load_ok) begin
            mem[load_ext[AW-1:0]] <= load_value;
        end
        if (cmd.probe) begin
            rd_data_reg <= $signed(mem[mid_ext[AW-1:0]]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg <= $signed(search_key);
        end
        if (cmd.probe) begin
            mid_reg <= mid_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg      <= '0;
            high_reg     <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            if (cmd.start) begin
                low_reg  <= '0;
                high_reg <= count_clamped;
                hit_reg  <= 1'b0;
            end else if (cmd.update) begin
                if (cmp_eq) begin
                    hit_reg <= 1'b1;
                end else if (cmp_lt) begin
                    low_reg <= LOW_W'(mid_reg + HIGH_W'(1));
                end else begin
                    high_reg <= mid_reg;
                end
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
                found_reg    <= hit_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    a_mid_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.probe |=> (mid_reg >= HIGH_W'(low_reg)) && (mid_reg < high_reg))
        else $error("probe index outside live range");

    a_finish_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !m_tvalid_reg || m_tready)
        else $error("result written over a waiting item");

    a_high_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> 32'(high_reg) <= 32'(TABLE_DEPTH))
        else $error("upper bound beyond table depth");

endmodule

`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
// Binary search over a sorted table of signed 32-bit entries.
// Input channel s_*: tuser = req_type (0 load, 1 search); tdata packs
// load_index, load_value and search_key from bit 0 up. A load writes
// one entry and gives no result; a load at an index at or beyond the
// table depth is dropped. A search gives one item on m_*: tdata[0] = found.
// APB register 0 (byte address 0): entry_count, 11 bits, clamped to the
// table depth when used. Write it only while the block is idle.
// A search makes p probes, p being at most floor(log2(entry_count)) + 1
// (11 for a full 1024-entry table); a search that meets the key stops
// probing at once, and one that misses stops when the range is empty.
// Each probe costs one registered table read followed by one signed
// compare.
// The block handles one item at a time; it takes a new item as soon as
// the result is in the output register, while that item still waits.
// Reset clears entry_count, the bounds and the output register; the table
// contents stay undefined until written. When m_tready is low the result
// holds, and a later search waits in its last step until it is taken.
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [9:0] load_index, [41:10] load_value, [73:42] search_key, rest zero
    input  wire logic [stbs_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] found, rest zero
    output logic [stbs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [stbs_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [stbs_pkg::PDATA_W-1:0]  pwdata,
    output logic [stbs_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import stbs_pkg::*;

    logic [COUNT_W-1:0] entry_count_reg;
    logic               reg_sel;
    logic               found;
    cmd_t               cmd;
    status_t            status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1] == REG_ENTRY_COUNT;
    assign prdata  = reg_sel ? PDATA_W'(entry_count_reg) : '0;
    assign m_tdata = M_TDATA_W'(found);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            entry_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    stbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .entry_count (entry_count_reg),
        .load_index  (s_tdata[INDEX_W-1:0]),
        .load_value  (s_tdata[INDEX_W+KEY_W-1:INDEX_W]),
        .search_key  (s_tdata[INDEX_W+2*KEY_W-1:INDEX_W+KEY_W]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .found       (found)
    );

endmodule

`default_nettype wire

// ===== bench/sorted_table_binary_search_test.sv =====
`default_nettype none

module sorted_table_binary_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 220;
    localparam int SETTLE       = 30;

    localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = REQ_LOAD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic signed [KEY_W-1:0] table_mirror [DEPTH];
    logic [COUNT_W-1:0]      mirror_count = '0;
    logic                    expected_found [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int failures      = 0;
    int cycle_count   = 0;

    sorted_table_binary_search #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_table_binary_search_test NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : check_found
        logic want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_found.size() == 0) begin
                $error("found: expected none pending, actual %0b", m_tdata[0]);
                failures++;
            end else begin
                want = expected_found.pop_front();
                if (m_tdata[0] !== want) begin
                    $error("found: expected %0b, actual %0b", want, m_tdata[0]);
                    failures++;
                end
            end
        end
    end

    function automatic logic search_table(input logic signed [KEY_W-1:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = (mirror_count > DEPTH) ? DEPTH : mirror_count;
        while (lo < hi) begin
            mid = lo + (hi - 1 - lo) / 2;
            if (table_mirror[mid] == key) return 1'b1;
            if (table_mirror[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        return 1'b0;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input int live);
        logic [KEY_W-1:0] hit;
        if (live == 0) return $urandom;
        hit = table_mirror[$urandom_range(live - 1)];
        case ($urandom_range(3))
            0, 1: return hit;
            2: return $urandom_range(1) ? hit + 1 : hit - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic req, input logic [INDEX_W-1:0] idx,
                             input logic [KEY_W-1:0] value, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, key, value, idx};
        do @(posedge aclk); while (!s_tready);
        if (req == REQ_LOAD) table_mirror[idx] = value;
        else expected_found.push_back(search_table(key));
        items_sent++;
    endtask

    task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [KEY_W-1:0] value);
        send_item(REQ_LOAD, idx, value, $urandom);
    endtask

    task automatic search_for(input logic [KEY_W-1:0] key);
        send_item(REQ_SEARCH, INDEX_W'($urandom), $urandom, key);
    endtask

    // drop valid and hold until every search has answered and the last load is done
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_found.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_entry_count(input logic [COUNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENTRY_COUNT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        mirror_count = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== PDATA_W'(mirror_count)) begin
            $error("entry_count: expected %0d, actual %0d", mirror_count, prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_empty_table();
        search_for(KEY_MIN);
        search_for(KEY_MAX);
        load_entry(10'd1023, KEY_MAX);
        load_entry(10'd0, KEY_MIN);
        wait_idle();
        write_entry_count('0);
        search_for('0);
        search_for(KEY_MIN);
    endtask

    task automatic test_edge_values();
        load_entry(10'd0, KEY_MIN);
        load_entry(10'd1, -32'sd1);
        load_entry(10'd2, 32'sd0);
        load_entry(10'd3, 32'sd1);
        load_entry(10'd4, 32'sd5);
        load_entry(10'd5, KEY_MAX);
        wait_idle();
        write_entry_count(11'd6);
        search_for(KEY_MIN);
        search_for(KEY_MAX);
        search_for(32'sd0);
        search_for(32'sd5);
        search_for(32'sd3);
        search_for(-32'sd2);
        search_for(KEY_MAX - 1);
        wait_idle();
        write_entry_count(11'd1);
        search_for(KEY_MIN);
        search_for(KEY_MAX);
    endtask

    // out-of-order entries: a key off the probe path is missed
    task automatic test_unsorted_probe();
        load_entry(10'd0, 32'sd7);
        load_entry(10'd1, 32'sd3);
        load_entry(10'd2, -32'sd9);
        wait_idle();
        write_entry_count(11'd3);
        search_for(32'sd3);
        search_for(-32'sd9);
        search_for(32'sd7);
    endtask

    task automatic test_full_table();
        logic [21:0] low;
        for (int i = 0; i < DEPTH; i++) begin
            low = (i == 0) ? '0 : (i == DEPTH - 1) ? '1 : 22'($urandom);
            load_entry(INDEX_W'(i), {INDEX_W'(i) ^ 10'h200, low});
        end
        wait_idle();
        write_entry_count(11'd1024);
        search_for(KEY_MIN);
        search_for(KEY_MAX);
        search_for(table_mirror[511]);
        search_for(table_mirror[512]);
        repeat (12) search_for(pick_key(DEPTH));
        wait_idle();
        write_entry_count(11'd2047);
        search_for(KEY_MIN);
        search_for(KEY_MAX);
        repeat (6) search_for(pick_key(DEPTH));
    endtask

    task automatic run_round();
        int n;
        int live;
        int r;
        int pos;
        int v;
        int vals [$];
        bit narrow;
        bit ordered;
        r = $urandom_range(99);
        if (r < 5) n = 0;
        else if (r < 12) n = $urandom_range(2047, 1000);
        else n = $urandom_range(40, 1);
        live = (n > DEPTH) ? DEPTH : n;
        wait_idle();
        write_entry_count(COUNT_W'(n));
        if (n <= 40) begin
            narrow  = ($urandom_range(9) < 3);
            ordered = ($urandom_range(9) != 0);
            for (int i = 0; i < n; i++) begin
                v = narrow ? int'($urandom_range(20)) - 10 : int'($urandom);
                pos = vals.size();
                if (ordered) begin
                    while (pos > 0 && vals[pos - 1] > v) pos--;
                end
                vals.insert(pos, v);
            end
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0) load_entry(INDEX_W'($urandom_range(DEPTH - 1, n)), $urandom);
                load_entry(INDEX_W'(i), vals[i]);
            end
        end
        repeat ($urandom_range(12, 4)) begin
            if (live > 0 && $urandom_range(9) == 0) load_entry(INDEX_W'($urandom_range(live - 1)), $urandom);
            search_for(pick_key(live));
        end
    endtask

    task automatic test_random_rounds(input int send_pct, input int recv_pct);
        int start;
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS / 4) run_round();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_edge_values();
        test_unsorted_probe();
        test_full_table();
        test_random_rounds(0, 0);
        test_random_rounds(77, 0);
        test_random_rounds(0, 77);
        test_random_rounds(37, 37);
        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (failures == 0) begin
            $display("sorted_table_binary_search_test OK");
        end else begin
            $display("sorted_table_binary_search_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/stbs_pkg.sv
rtl/stbs_ctrl.sv
rtl/stbs_datapath.sv
rtl/sorted_table_binary_search.sv
bench/sorted_table_binary_search_test.sv
